[hdl/bfst_pkg.sv]
`timescale 1ns / 1ps

package bfst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int STEP_W      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH - 1) : 1;

  localparam logic [2:0] KIND_APPEND     = 3'd0;
  localparam logic [2:0] KIND_LOOKUP     = 3'd1;
  localparam logic [2:0] KIND_DEL_PAIR   = 3'd2;
  localparam logic [2:0] KIND_DEL_HANDLE = 3'd3;
  localparam logic [2:0] KIND_CLEAR      = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic                   valid;
    logic [31:0]            src;
    logic [31:0]            dst;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // Carried up the chain: any hit below, and the handle of the lowest hit.
  typedef struct packed {
    logic                   prior;
    logic [HANDLE_BITS-1:0] hcar;
  } link_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic del;
    logic app;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_APPLY
  } state_t;

endpackage

[hdl/bfst_cell.sv]
`timescale 1ns / 1ps

module bfst_cell (
  input  logic              clk,
  input  logic              rst,
  input  bfst_pkg::cell_ctl_t ctl,
  input  bfst_pkg::req_t    query,
  input  bfst_pkg::entry_t  lower_entry,
  input  bfst_pkg::entry_t  upper_entry,
  input  bfst_pkg::link_t   link_in,
  output bfst_pkg::entry_t  entry,
  output bfst_pkg::link_t   link_out
);

  logic                             valid;
  logic [31:0]                      src;
  logic [31:0]                      dst;
  logic [bfst_pkg::HANDLE_BITS-1:0] handle;
  logic                             hit;
  logic                             prior;
  logic [bfst_pkg::HANDLE_BITS-1:0] hcar;

  logic                             hit_next;
  logic                             pair_hit;
  logic                             hdl_hit;
  logic                             shift_in;
  logic                             load_new;

  assign entry = '{valid: valid, src: src, dst: dst, handle: handle};

  assign link_out.prior = prior | hit;
  assign link_out.hcar  = prior ? hcar : (hit ? handle : '0);

  assign pair_hit = valid && (((src == query.src_addr) && (dst == query.dst_addr)) ||
                              ((src == query.dst_addr) && (dst == query.src_addr)));
  assign hdl_hit  = valid && (handle == bfst_pkg::HANDLE_BITS'(query.handle_in));

  always_comb begin
    case (query.kind)
      bfst_pkg::KIND_LOOKUP,
      bfst_pkg::KIND_DEL_PAIR:   hit_next = pair_hit;
      bfst_pkg::KIND_DEL_HANDLE: hit_next = hdl_hit;
      default:                   hit_next = 1'b0;
    endcase
  end

  // Close the gap at and above the oldest hit; fill the first free slot.
  assign shift_in = ctl.del && (prior || hit);
  assign load_new = ctl.app && !valid && lower_entry.valid;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit   <= hit_next;
      prior <= 1'b0;
      hcar  <= '0;
    end else if (ctl.step) begin
      prior <= link_in.prior;
      hcar  <= link_in.hcar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (shift_in) begin
      valid <= upper_entry.valid;
    end else if (load_new) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      src    <= upper_entry.src;
      dst    <= upper_entry.dst;
      handle <= upper_entry.handle;
    end else if (load_new) begin
      src    <= query.src_addr;
      dst    <= query.dst_addr;
      handle <= bfst_pkg::HANDLE_BITS'(query.handle_in);
    end
  end

endmodule

[hdl/bidirectional_flow_session_table_top.sv]
`timescale 1ns / 1ps
// Channel | Handshake            | Word            | Meaning
// req     | req_valid/req_stall  | bfst_pkg::req_t | command: append, lookup, delete, clear
// rsp     | rsp_valid/rsp_stall  | bfst_pkg::rsp_t | status, found handle, entry count
//
// Append, clear and unknown kinds pass through accept and apply; lookup and both
// deletes pass through accept, TABLE_DEPTH - 1 chain steps and apply; the steps move
// the hit flag and handle up the cell chain one cell per cycle.
// A new word is taken the cycle after apply. Reset (rst, synchronous) empties the
// table at once. A stalled response holds apply until the output register frees.

module bidirectional_flow_session_table_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bfst_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bfst_pkg::rsp_t rsp
);

  localparam bfst_pkg::entry_t ENTRY_BASE  = '{valid: 1'b1, src: '0, dst: '0, handle: '0};
  localparam bfst_pkg::entry_t ENTRY_EMPTY = '{valid: 1'b0, src: '0, dst: '0, handle: '0};
  localparam bfst_pkg::link_t  LINK_NONE   = '{prior: 1'b0, hcar: '0};

  bfst_pkg::state_t                state;
  bfst_pkg::state_t                state_next;
  logic [bfst_pkg::STEP_W-1:0]     step;
  bfst_pkg::req_t                  q;
  logic [bfst_pkg::CNT_W-1:0]      count;
  logic [bfst_pkg::CNT_W-1:0]      count_next;
  bfst_pkg::rsp_t                  rsp_next;

  logic                            req_fire;
  logic                            apply_go;
  logic                            sweep_done;
  logic                            is_search;
  logic                            is_full;
  bfst_pkg::cell_ctl_t             ctl;
  bfst_pkg::req_t                  query;
  bfst_pkg::link_t                 fin;

  bfst_pkg::entry_t                ent [bfst_pkg::TABLE_DEPTH];
  bfst_pkg::link_t                 lnk [bfst_pkg::TABLE_DEPTH];

  // Cell chain: entry 0 is the oldest. Links run upward, entries shift downward.
  for (genvar i = 0; i < bfst_pkg::TABLE_DEPTH; i++) begin : g_cell
    bfst_pkg::entry_t lower;
    bfst_pkg::entry_t upper;
    bfst_pkg::link_t  lin;

    if (i == 0) begin : g_first
      assign lower = ENTRY_BASE;
      assign lin   = LINK_NONE;
    end else begin : g_mid
      assign lower = ent[i-1];
      assign lin   = lnk[i-1];
    end

    if (i == bfst_pkg::TABLE_DEPTH - 1) begin : g_last
      assign upper = ENTRY_EMPTY;
    end else begin : g_body
      assign upper = ent[i+1];
    end

    bfst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .query       (query),
      .lower_entry (lower),
      .upper_entry (upper),
      .link_in     (lin),
      .entry       (ent[i]),
      .link_out    (lnk[i])
    );
  end

  assign fin        = lnk[bfst_pkg::TABLE_DEPTH-1];
  assign req_fire   = req_valid && !req_stall;
  assign sweep_done = (step == bfst_pkg::STEP_W'(bfst_pkg::TABLE_DEPTH - 2));
  assign is_search  = (req.kind == bfst_pkg::KIND_LOOKUP) ||
                      (req.kind == bfst_pkg::KIND_DEL_PAIR) ||
                      (req.kind == bfst_pkg::KIND_DEL_HANDLE);
  assign is_full    = (count == bfst_pkg::CNT_W'(bfst_pkg::TABLE_DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bfst_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = is_search ? bfst_pkg::S_SWEEP : bfst_pkg::S_APPLY;
        end
      end
      bfst_pkg::S_SWEEP: begin
        if (sweep_done) begin
          state_next = bfst_pkg::S_APPLY;
        end
      end
      bfst_pkg::S_APPLY: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = bfst_pkg::S_IDLE;
        end
      end
      default: state_next = bfst_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req_stall   = 1'b1;
    apply_go    = 1'b0;
    ctl         = '0;
    query       = q;
    case (state)
      bfst_pkg::S_IDLE: begin
        req_stall   = 1'b0;
        query       = req;
        ctl.capture = req_valid;
      end
      bfst_pkg::S_SWEEP: begin
        ctl.step = 1'b1;
      end
      bfst_pkg::S_APPLY: begin
        apply_go = !rsp_valid || !rsp_stall;
        ctl.del  = apply_go && ((q.kind == bfst_pkg::KIND_DEL_PAIR) ||
                                (q.kind == bfst_pkg::KIND_DEL_HANDLE));
        ctl.app  = apply_go && (q.kind == bfst_pkg::KIND_APPEND) && !is_full;
        ctl.clr  = apply_go && (q.kind == bfst_pkg::KIND_CLEAR);
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Result word and count after this item.
  always_comb begin
    count_next          = count;
    rsp_next.status     = bfst_pkg::STATUS_MISS;
    rsp_next.handle_out = '0;
    case (q.kind)
      bfst_pkg::KIND_APPEND: begin
        if (is_full) begin
          rsp_next.status = bfst_pkg::STATUS_FULL;
        end else begin
          rsp_next.status = bfst_pkg::STATUS_OK;
          count_next      = count + 1'b1;
        end
      end
      bfst_pkg::KIND_LOOKUP: begin
        if (fin.prior) begin
          rsp_next.status     = bfst_pkg::STATUS_OK;
          rsp_next.handle_out = 16'(fin.hcar);
        end
      end
      bfst_pkg::KIND_DEL_PAIR,
      bfst_pkg::KIND_DEL_HANDLE: begin
        if (fin.prior) begin
          rsp_next.status = bfst_pkg::STATUS_OK;
          count_next      = count - 1'b1;
        end
      end
      bfst_pkg::KIND_CLEAR: begin
        rsp_next.status = bfst_pkg::STATUS_OK;
        count_next      = '0;
      end
      default: begin
        rsp_next.status = bfst_pkg::STATUS_MISS;
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfst_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the command; advance the chain step count during the sweep.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      q    <= req;
      step <= '0;
    end else if (state == bfst_pkg::S_SWEEP) begin
      step <= step + 1'b1;
    end
    if (apply_go) begin
      rsp <= rsp_next;
    end
  end

endmodule

[hdl/bfst_checker.sv]
`timescale 1ns / 1ps

module bfst_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input bfst_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input bfst_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second command taken while one is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == bfst_pkg::STATUS_FULL) |->
      (rsp.entry_count == 5'(bfst_pkg::TABLE_DEPTH)))
    else $error("full status with a table that is not full");

  a_handle_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.handle_out != 16'd0) |-> (rsp.status == bfst_pkg::STATUS_OK))
    else $error("handle reported without a hit");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entry_count <= 5'(bfst_pkg::TABLE_DEPTH)))
    else $error("entry count beyond table depth");

endmodule

bind bidirectional_flow_session_table_top bfst_checker u_bfst_checker (.*);
